### hdl/mse_pkg.sv
// Shared types and codes for the MIPS subset execute step.
// Holds request, status, opcode and function codes and the execute result struct.
// No dependencies.
package mse_pkg;

  // request codes
  localparam logic [1:0] REQ_EXEC    = 2'd0;
  localparam logic [1:0] REQ_PRELOAD = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_UNIMPL   = 2'd1;
  localparam logic [1:0] STATUS_BAD_ADDR = 2'd2;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_BNE   = 6'd5;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_ADDIU = 6'd9;
  localparam logic [5:0] OP_SLTI  = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_ANDI  = 6'd12;
  localparam logic [5:0] OP_ORI   = 6'd13;
  localparam logic [5:0] OP_LUI   = 6'd15;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // function codes of register-type instructions
  localparam logic [5:0] FN_SLL  = 6'd0;
  localparam logic [5:0] FN_SRL  = 6'd2;
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADD  = 6'd32;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUB  = 6'd34;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_AND  = 6'd36;
  localparam logic [5:0] FN_OR   = 6'd37;
  localparam logic [5:0] FN_SLT  = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  // data memory sits in the 0x1xxxxxxx segment
  localparam logic [3:0] DATA_SEGMENT = 4'h1;
  localparam logic [4:0] LINK_REG     = 5'd31;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  dst;
    logic [31:0] val;
    logic        wr;
    logic [31:0] rd_val;
    logic [1:0]  status;
    logic        is_load;
    logic        mem_we;
    logic [29:0] mem_idx;
    logic [31:0] mem_wdata;
  } exec_res_t;

endpackage

### hdl/mse_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/mse_exec.sv
// Execute unit: decodes one request and computes its result, next pc and memory access.
// Depends on mse_pkg.
module mse_exec #(
  parameter int DATA_WORDS = 16384
) (
  input  logic [1:0]         opcode,
  input  logic [31:0]        instruction,
  input  logic [13:0]        word_index,
  input  logic [31:0]        word_value,
  input  logic [31:0]        pc,
  input  logic [31:0]        rs_val,
  input  logic [31:0]        rt_val,
  output mse_pkg::exec_res_t res
);
  import mse_pkg::*;

  logic [5:0]  op;
  logic [5:0]  funct;
  logic [4:0]  rt_idx;
  logic [4:0]  rd_idx;
  logic [4:0]  shamt;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] eff;
  logic        eff_ok;
  logic        want_wr;
  logic [4:0]  want_dst;
  logic [31:0] want_val;

  assign op     = instruction[31:26];
  assign funct  = instruction[5:0];
  assign rt_idx = instruction[20:16];
  assign rd_idx = instruction[15:11];
  assign shamt  = instruction[10:6];
  assign imm    = {16'd0, instruction[15:0]};
  assign simm   = {{16{instruction[15]}}, instruction[15:0]};
  assign pc4    = pc + 32'd4;

  // effective data address and its range check
  assign eff    = rs_val + simm;
  assign eff_ok = (eff[31:28] == DATA_SEGMENT) && (eff[1:0] == 2'b00)
                  && ({6'd0, eff[27:2]} < 32'(DATA_WORDS));

  // decode and execute
  always_comb begin
    res          = '0;
    res.next_pc  = pc;
    want_wr      = 1'b0;
    want_dst     = rt_idx;
    want_val     = '0;
    case (opcode)
      REQ_EXEC: begin
        res.next_pc = pc4;
        if (op == OP_RTYPE) begin
          want_dst = rd_idx;
          case (funct)
            FN_SLL: begin
              want_wr  = 1'b1;
              want_val = rt_val << shamt;
            end
            FN_SRL: begin
              want_wr  = 1'b1;
              want_val = rt_val >> shamt;
            end
            FN_JR: res.next_pc = rs_val;
            FN_ADD, FN_ADDU: begin
              want_wr  = 1'b1;
              want_val = rs_val + rt_val;
            end
            FN_SUB, FN_SUBU: begin
              want_wr  = 1'b1;
              want_val = rs_val - rt_val;
            end
            FN_AND: begin
              want_wr  = 1'b1;
              want_val = rs_val & rt_val;
            end
            FN_OR: begin
              want_wr  = 1'b1;
              want_val = rs_val | rt_val;
            end
            FN_SLT: begin
              want_wr  = 1'b1;
              want_val = {31'd0, $signed(rs_val) < $signed(rt_val)};
            end
            FN_SLTU: begin
              want_wr  = 1'b1;
              want_val = {31'd0, rs_val < rt_val};
            end
            default: res.status = STATUS_UNIMPL;
          endcase
        end else begin
          case (op)
            OP_J: res.next_pc = {pc4[31:28], instruction[25:0], 2'b00};
            OP_JAL: begin
              res.next_pc = {pc4[31:28], instruction[25:0], 2'b00};
              want_wr     = 1'b1;
              want_dst    = LINK_REG;
              want_val    = pc4;
            end
            OP_BEQ: begin
              if (rs_val == rt_val) begin
                res.next_pc = pc4 + {simm[29:0], 2'b00};
              end
            end
            OP_BNE: begin
              if (rs_val != rt_val) begin
                res.next_pc = pc4 + {simm[29:0], 2'b00};
              end
            end
            OP_ADDI, OP_ADDIU: begin
              want_wr  = 1'b1;
              want_val = rs_val + simm;
            end
            OP_SLTI: begin
              want_wr  = 1'b1;
              want_val = {31'd0, $signed(rs_val) < $signed(simm)};
            end
            OP_SLTIU: begin
              want_wr  = 1'b1;
              want_val = {31'd0, rs_val < simm};
            end
            OP_ANDI: begin
              want_wr  = 1'b1;
              want_val = rs_val & imm;
            end
            OP_ORI: begin
              want_wr  = 1'b1;
              want_val = rs_val | imm;
            end
            OP_LUI: begin
              want_wr  = 1'b1;
              want_val = {instruction[15:0], 16'd0};
            end
            OP_LW: begin
              res.mem_idx = eff[31:2];
              if (eff_ok) begin
                want_wr     = 1'b1;
                res.is_load = (rt_idx != 5'd0);
              end else begin
                res.status = STATUS_BAD_ADDR;
              end
            end
            OP_SW: begin
              res.mem_idx   = eff[31:2];
              res.mem_wdata = rt_val;
              if (eff_ok) begin
                res.mem_we = 1'b1;
              end else begin
                res.status = STATUS_BAD_ADDR;
              end
            end
            default: res.status = STATUS_UNIMPL;
          endcase
        end
      end
      REQ_PRELOAD: begin
        res.mem_idx   = {16'd0, word_index};
        res.mem_wdata = word_value;
        if (32'(word_index) < 32'(DATA_WORDS)) begin
          res.mem_we = 1'b1;
        end else begin
          res.status = STATUS_BAD_ADDR;
        end
      end
      REQ_READ: res.rd_val = rs_val;
      default:  res.status = STATUS_UNIMPL;
    endcase

    // drop writes to register zero
    if (want_wr && (want_dst != 5'd0)) begin
      res.wr  = 1'b1;
      res.dst = want_dst;
      res.val = want_val;
    end
  end

endmodule

### hdl/mips_subset_execute_step.sv
// MIPS32 integer subset execute step: one request per item (execute, preload, read).
// Uses mse_pkg, mse_ram for the register file and data memory, and mse_exec.
//
// Usage:
//   Input channel in_valid/in_stall carries opcode, instruction, word_index,
//   word_value and register_index; a request is taken when in_valid is high
//   and in_stall is low. Output channel out_valid/out_stall carries next_pc,
//   dest_register, dest_value, register_written, read_value and status; one
//   result per request, in order.
//   Path: a request goes through the first stage, then the result register.
//   Throughput: one request per cycle while in_stall is low; register reads
//   go through the register file RAM in the cycle of acceptance, the data
//   memory access when the first stage moves on; earlier results are forwarded.
//   Reset: the register file reads as zero and the pc is zero at once; the
//   data memory is then filled with all ones, one word a cycle, until all
//   DATA_WORDS words are written, with in_stall held high meanwhile.
//   Receiver stall: the result register holds; one more request may be taken
//   into the first stage, after which in_stall rises until out_stall drops.
module mips_subset_execute_step #(
  parameter int DATA_WORDS = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] instruction,
  input  logic [13:0] word_index,
  input  logic [31:0] word_value,
  input  logic [4:0]  register_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] next_pc,
  output logic [4:0]  dest_register,
  output logic [31:0] dest_value,
  output logic        register_written,
  output logic [31:0] read_value,
  output logic [1:0]  status
);
  import mse_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  // handshake and pipeline control
  logic        in_fire;
  logic        s1_fire;
  logic        s2_fire;
  logic        s2_free;

  // first stage: request plus register read addresses
  logic        s1_valid;
  logic [1:0]  s1_opcode;
  logic [31:0] s1_instruction;
  logic [13:0] s1_word_index;
  logic [31:0] s1_word_value;
  logic [4:0]  s1_addr_a;
  logic [4:0]  s1_addr_b;

  // second stage: result register
  logic        s2_valid;
  logic [31:0] s2_next_pc;
  logic [4:0]  s2_dst;
  logic [31:0] s2_val;
  logic        s2_wr;
  logic [31:0] s2_rd_val;
  logic [1:0]  s2_status;
  logic        s2_is_load;
  logic [31:0] s2_wval;

  // last register write committed
  logic        last_wr;
  logic [4:0]  last_dst;
  logic [31:0] last_val;

  // architectural state in flops
  logic [31:0] pc;
  logic [31:0] rf_valid;

  // data memory clearing sweep
  logic          clr_busy;
  logic [AW-1:0] clr_idx;

  // memory ports
  logic [4:0]    rf_raddr_a;
  logic [4:0]    rf_raddr_b;
  logic [31:0]   rf_rdata_a;
  logic [31:0]   rf_rdata_b;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [31:0]   dm_wdata;
  logic [31:0]   dm_rdata;

  logic [31:0] rs_val;
  logic [31:0] rt_val;
  exec_res_t   res;

  assign s2_free  = !s2_valid || !out_stall;
  assign s2_fire  = s2_valid && !out_stall;
  assign s1_fire  = s1_valid && s2_free;
  assign in_stall = clr_busy || (s1_valid && !s2_free);
  assign in_fire  = in_valid && !in_stall;

  // register file read addresses at acceptance
  assign rf_raddr_a = (opcode == REQ_READ) ? register_index : instruction[25:21];
  assign rf_raddr_b = instruction[20:16];

  // two register file copies give two read ports
  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk   (clk),
    .we    (s2_fire && s2_wr),
    .waddr (s2_dst),
    .wdata (s2_wval),
    .re    (in_fire),
    .raddr (rf_raddr_a),
    .rdata (rf_rdata_a)
  );

  mse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk   (clk),
    .we    (s2_fire && s2_wr),
    .waddr (s2_dst),
    .wdata (s2_wval),
    .re    (in_fire),
    .raddr (rf_raddr_b),
    .rdata (rf_rdata_b)
  );

  // value that the second stage will write
  assign s2_wval = s2_is_load ? dm_rdata : s2_val;

  // forward operand A: result stage, last commit, RAM, else reset zero
  always_comb begin
    if (s2_valid && s2_wr && (s2_dst == s1_addr_a)) begin
      rs_val = s2_wval;
    end else if (last_wr && (last_dst == s1_addr_a)) begin
      rs_val = last_val;
    end else if (rf_valid[s1_addr_a]) begin
      rs_val = rf_rdata_a;
    end else begin
      rs_val = '0;
    end
  end

  // forward operand B the same way
  always_comb begin
    if (s2_valid && s2_wr && (s2_dst == s1_addr_b)) begin
      rt_val = s2_wval;
    end else if (last_wr && (last_dst == s1_addr_b)) begin
      rt_val = last_val;
    end else if (rf_valid[s1_addr_b]) begin
      rt_val = rf_rdata_b;
    end else begin
      rt_val = '0;
    end
  end

  mse_exec #(.DATA_WORDS(DATA_WORDS)) u_exec (
    .opcode      (s1_opcode),
    .instruction (s1_instruction),
    .word_index  (s1_word_index),
    .word_value  (s1_word_value),
    .pc          (pc),
    .rs_val      (rs_val),
    .rt_val      (rt_val),
    .res         (res)
  );

  // data memory port: clearing sweep or first-stage access
  assign dm_we    = clr_busy || (s1_fire && res.mem_we);
  assign dm_waddr = clr_busy ? clr_idx : res.mem_idx[AW-1:0];
  assign dm_wdata = clr_busy ? '1 : res.mem_wdata;

  mse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (s1_fire),
    .raddr (res.mem_idx[AW-1:0]),
    .rdata (dm_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      last_wr  <= 1'b0;
      pc       <= '0;
      rf_valid <= '0;
      clr_busy <= 1'b1;
      clr_idx  <= '0;
    end else begin
      // advance the sweep
      if (clr_busy) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == AW'(DATA_WORDS - 1)) begin
          clr_busy <= 1'b0;
        end
      end
      // advance the first stage
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      // advance the result stage
      if (s1_fire) begin
        s2_valid <= 1'b1;
        pc       <= res.next_pc;
      end else if (s2_fire) begin
        s2_valid <= 1'b0;
      end
      // commit register writes
      if (s2_fire && s2_wr) begin
        last_wr            <= 1'b1;
        rf_valid[s2_dst]   <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_opcode      <= opcode;
      s1_instruction <= instruction;
      s1_word_index  <= word_index;
      s1_word_value  <= word_value;
      s1_addr_a      <= rf_raddr_a;
      s1_addr_b      <= rf_raddr_b;
    end
    if (s1_fire) begin
      s2_next_pc <= res.next_pc;
      s2_dst     <= res.dst;
      s2_val     <= res.val;
      s2_wr      <= res.wr;
      s2_rd_val  <= res.rd_val;
      s2_status  <= res.status;
      s2_is_load <= res.is_load;
    end
    if (s2_fire && s2_wr) begin
      last_dst <= s2_dst;
      last_val <= s2_wval;
    end
  end

  // drive the result channel
  assign out_valid        = s2_valid;
  assign next_pc          = s2_next_pc;
  assign dest_register    = s2_dst;
  assign dest_value       = s2_wval;
  assign register_written = s2_wr;
  assign read_value       = s2_rd_val;
  assign status           = s2_status;

endmodule

### sim/tb_mips_subset_execute_step.sv
// Testbench for mips_subset_execute_step: drives execute, preload and read requests,
// predicts each result from a mirrored register file, pc and data memory, and checks it.
// Depends on mse_pkg and the mips_subset_execute_step RTL.
module tb_mips_subset_execute_step;
  import mse_pkg::*;

  localparam int DMEM_WORDS = 16384;
  localparam logic [31:0] DATA_BASE = 32'h1000_0000;
  // watchdog limit leaves room for the data memory fill after reset
  localparam int WATCHDOG_LIMIT = 3 * DMEM_WORDS + 2000;
  localparam int DRAIN_CYCLES = 8;

  // codes the block does not implement
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam logic [5:0] FN_XOR = 6'd38;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  dest_reg;
    logic [31:0] dest_val;
    logic        wrote;
    logic [31:0] reg_read;
    logic [1:0]  status;
  } step_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] instruction;
  logic [13:0] word_index;
  logic [31:0] word_value;
  logic [4:0]  register_index;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] next_pc;
  logic [4:0]  dest_register;
  logic [31:0] dest_value;
  logic        register_written;
  logic [31:0] read_value;
  logic [1:0]  status;

  // mirrored architectural state
  logic [31:0] gpr [32];
  logic [31:0] pc_q;
  logic [31:0] dmem [DMEM_WORDS];

  step_result_t step_results[$];
  int error_count = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;

  mips_subset_execute_step #(.DATA_WORDS(DMEM_WORDS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .instruction(instruction),
    .word_index(word_index),
    .word_value(word_value),
    .register_index(register_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .next_pc(next_pc),
    .dest_register(dest_register),
    .dest_value(dest_value),
    .register_written(register_written),
    .read_value(read_value),
    .status(status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the mirrored state by one request and return what the block should report.
  function automatic step_result_t mips_step(input logic [1:0] req, input logic [31:0] ins,
      input logic [13:0] widx, input logic [31:0] wval, input logic [4:0] ridx);
    step_result_t r;
    logic [31:0] rs_v, rt_v, simm, target, addr, slot, wr_val;
    logic [4:0] rt_n, wr_idx;
    logic do_wr, addr_ok;
    r = '0;
    do_wr = 1'b0;
    wr_idx = '0;
    wr_val = '0;
    case (req)
      REQ_EXEC: begin
        pc_q = pc_q + 32'd4;
        rs_v = gpr[ins[25:21]];
        rt_n = ins[20:16];
        rt_v = gpr[rt_n];
        simm = {{16{ins[15]}}, ins[15:0]};
        target = {pc_q[31:28], ins[25:0], 2'b00};
        addr = rs_v + simm;
        slot = (addr - DATA_BASE) >> 2;
        addr_ok = (addr[1:0] == 2'b00) && (addr >= DATA_BASE) && (slot < DMEM_WORDS);
        if (ins[31:26] == OP_RTYPE) begin
          do_wr = 1'b1;
          wr_idx = ins[15:11];
          case (ins[5:0])
            FN_SLL: wr_val = rt_v << ins[10:6];
            FN_SRL: wr_val = rt_v >> ins[10:6];
            FN_ADD, FN_ADDU: wr_val = rs_v + rt_v;
            FN_SUB, FN_SUBU: wr_val = rs_v - rt_v;
            FN_AND: wr_val = rs_v & rt_v;
            FN_OR: wr_val = rs_v | rt_v;
            FN_SLT: wr_val = {31'd0, $signed(rs_v) < $signed(rt_v)};
            FN_SLTU: wr_val = {31'd0, rs_v < rt_v};
            FN_JR: begin
              do_wr = 1'b0;
              pc_q = rs_v;
            end
            default: begin
              do_wr = 1'b0;
              r.status = STATUS_UNIMPL;
            end
          endcase
        end else begin
          do_wr = 1'b1;
          wr_idx = rt_n;
          case (ins[31:26])
            OP_J: begin
              do_wr = 1'b0;
              pc_q = target;
            end
            OP_JAL: begin
              wr_idx = LINK_REG;
              wr_val = pc_q;
              pc_q = target;
            end
            OP_BEQ: begin
              do_wr = 1'b0;
              if (rs_v == rt_v) pc_q = pc_q + (simm << 2);
            end
            OP_BNE: begin
              do_wr = 1'b0;
              if (rs_v != rt_v) pc_q = pc_q + (simm << 2);
            end
            OP_ADDI, OP_ADDIU: wr_val = rs_v + simm;
            OP_SLTI: wr_val = {31'd0, $signed(rs_v) < $signed(simm)};
            OP_SLTIU: wr_val = {31'd0, rs_v < simm};
            OP_ANDI: wr_val = rs_v & {16'd0, ins[15:0]};
            OP_ORI: wr_val = rs_v | {16'd0, ins[15:0]};
            OP_LUI: wr_val = {ins[15:0], 16'd0};
            OP_LW: begin
              if (addr_ok) begin
                wr_val = dmem[slot];
              end else begin
                do_wr = 1'b0;
                r.status = STATUS_BAD_ADDR;
              end
            end
            OP_SW: begin
              do_wr = 1'b0;
              if (addr_ok) dmem[slot] = rt_v;
              else r.status = STATUS_BAD_ADDR;
            end
            default: begin
              do_wr = 1'b0;
              r.status = STATUS_UNIMPL;
            end
          endcase
        end
        // drop writes to $0
        if (do_wr && wr_idx != 5'd0) begin
          gpr[wr_idx] = wr_val;
          r.dest_reg = wr_idx;
          r.dest_val = wr_val;
          r.wrote = 1'b1;
        end
      end
      REQ_PRELOAD: begin
        if (32'(widx) < DMEM_WORDS) dmem[widx] = wval;
        else r.status = STATUS_BAD_ADDR;
      end
      REQ_READ: r.reg_read = gpr[ridx];
      default: r.status = STATUS_UNIMPL;
    endcase
    r.next_pc = pc_q;
    return r;
  endfunction

  function automatic logic [31:0] enc_r(input logic [5:0] fn, input logic [4:0] rs, rt, rd, sh);
    return {OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
      input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_j(input logic [5:0] op, input logic [25:0] tgt);
    return {op, tgt};
  endfunction

  // Favor a few low registers so results feed the next instructions.
  function automatic logic [4:0] pick_reg();
    logic [4:0] r;
    if ($urandom_range(0, 2) == 0) r = 5'($urandom);
    else r = 5'($urandom_range(0, 7));
    return r;
  endfunction

  function automatic logic [31:0] rand_alu_instr();
    logic [5:0] fn, op;
    logic [31:0] w;
    case ($urandom_range(0, 9))
      0: fn = FN_SLL;
      1: fn = FN_SRL;
      2: fn = FN_ADD;
      3: fn = FN_ADDU;
      4: fn = FN_SUB;
      5: fn = FN_SUBU;
      6: fn = FN_AND;
      7: fn = FN_OR;
      8: fn = FN_SLT;
      default: fn = FN_SLTU;
    endcase
    case ($urandom_range(0, 6))
      0: op = OP_ADDI;
      1: op = OP_ADDIU;
      2: op = OP_SLTI;
      3: op = OP_SLTIU;
      4: op = OP_ANDI;
      5: op = OP_ORI;
      default: op = OP_LUI;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: w = enc_r(fn, pick_reg(), pick_reg(), pick_reg(), 5'($urandom));
      4, 5, 6: w = enc_i(op, pick_reg(), pick_reg(), 16'($urandom));
      7: w = enc_i(($urandom_range(0, 1) == 0) ? OP_BEQ : OP_BNE, pick_reg(), pick_reg(),
                   16'($urandom));
      8: w = enc_j(($urandom_range(0, 1) == 0) ? OP_J : OP_JAL, 26'($urandom));
      default: w = enc_r(FN_JR, pick_reg(), 5'($urandom), 5'($urandom), 5'($urandom));
    endcase
    return w;
  endfunction

  // Present one request, hold it until taken, then record its predicted result.
  task automatic send_request(input logic [1:0] req, input logic [31:0] ins,
      input logic [13:0] widx, input logic [31:0] wval, input logic [4:0] ridx);
    if (tx_idle_en && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= req;
    instruction <= ins;
    word_index <= widx;
    word_value <= wval;
    register_index <= ridx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    step_results.push_back(mips_step(req, ins, widx, wval, ridx));
    if (req != REQ_UNKNOWN) items_sent++;
  endtask

  task automatic exec_instr(input logic [31:0] ins);
    send_request(REQ_EXEC, ins, 14'($urandom), $urandom, 5'($urandom));
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Check each result taken, stall the result side in bursts, and count quiet cycles.
  always @(posedge clk) begin : result_monitor
    step_result_t want;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (step_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got next_pc %h status %h",
                   $time, next_pc, status);
          error_count++;
        end else begin
          want = step_results.pop_front();
          check_field("next_pc", want.next_pc, next_pc);
          check_field("dest_register", 32'(want.dest_reg), 32'(dest_register));
          check_field("dest_value", want.dest_val, dest_value);
          check_field("register_written", 32'(want.wrote), 32'(register_written));
          check_field("read_value", want.reg_read, read_value);
          check_field("status", 32'(want.status), 32'(status));
        end
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 9);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Edge values, every operation and the corner cases, back to back.
  task automatic test_directed();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_request(REQ_READ, '0, '0, '0, 5'd0);
    exec_instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
    exec_instr(enc_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
    exec_instr(enc_i(OP_ADDI, 5'd0, 5'd3, 16'h7FFF));
    exec_instr(enc_r(FN_ADD, 5'd1, 5'd2, 5'd4, 5'd0));
    exec_instr(enc_r(FN_ADDU, 5'd2, 5'd2, 5'd5, 5'd0));
    exec_instr(enc_r(FN_SUB, 5'd1, 5'd3, 5'd6, 5'd0));
    exec_instr(enc_r(FN_SUBU, 5'd0, 5'd2, 5'd7, 5'd0));
    // signed versus unsigned compare of most negative against positive
    exec_instr(enc_r(FN_SLT, 5'd1, 5'd3, 5'd8, 5'd0));
    exec_instr(enc_r(FN_SLTU, 5'd1, 5'd3, 5'd9, 5'd0));
    exec_instr(enc_i(OP_SLTI, 5'd2, 5'd10, 16'h0000));
    // sign-extended immediate compared unsigned
    exec_instr(enc_i(OP_SLTIU, 5'd3, 5'd11, 16'hFFFF));
    exec_instr(enc_r(FN_SLL, 5'd0, 5'd2, 5'd12, 5'd31));
    exec_instr(enc_r(FN_SRL, 5'd0, 5'd2, 5'd13, 5'd31));
    exec_instr(enc_r(FN_AND, 5'd1, 5'd2, 5'd14, 5'd0));
    exec_instr(enc_r(FN_OR, 5'd3, 5'd1, 5'd15, 5'd0));
    exec_instr(enc_i(OP_ANDI, 5'd2, 5'd16, 16'h8001));
    exec_instr(enc_i(OP_ORI, 5'd1, 5'd17, 16'hFFFF));
    // write to $0 is dropped
    exec_instr(enc_i(OP_ADDI, 5'd2, 5'd0, 16'h0005));
    send_request(REQ_PRELOAD, '0, 14'h3FFF, 32'h1234_5678, '0);
    // $20 points one word past the data memory
    exec_instr(enc_i(OP_LUI, 5'd0, 5'd20, 16'h1001));
    exec_instr(enc_i(OP_LW, 5'd20, 5'd21, 16'hFFFC));
    exec_instr(enc_i(OP_SW, 5'd20, 5'd1, 16'hFFF8));
    exec_instr(enc_i(OP_LW, 5'd20, 5'd22, 16'hFFF8));
    exec_instr(enc_i(OP_LW, 5'd20, 5'd23, 16'h0000));
    exec_instr(enc_i(OP_SW, 5'd20, 5'd1, 16'hFFFE));
    exec_instr(enc_i(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
    exec_instr(enc_i(OP_BNE, 5'd1, 5'd2, 16'h7FFF));
    // jump target keeps the upper pc bits
    exec_instr(enc_r(FN_JR, 5'd1, 5'd0, 5'd0, 5'd0));
    exec_instr(enc_j(OP_J, 26'h3FF_FFFF));
    exec_instr(enc_j(OP_JAL, 26'h000_0000));
    // unaligned jump register target is taken as is
    exec_instr(enc_r(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));
    exec_instr(enc_r(FN_XOR, 5'd1, 5'd2, 5'd24, 5'd0));
    send_request(REQ_UNKNOWN, '1, '1, '1, '1);
    send_request(REQ_READ, '0, '0, '0, LINK_REG);
  endtask

  // Mostly short well-formed programs with random content, plus some noise.
  task automatic test_random_programs(input int count, input bit with_idle);
    int start, sel, k;
    logic [4:0] ptr;
    logic [15:0] off;
    logic [13:0] near;
    start = items_sent;
    while (items_sent - start < count) begin
      tx_idle_en = with_idle && ($urandom_range(0, 3) != 0);
      rx_idle_en = with_idle && ($urandom_range(0, 3) != 0);
      sel = $urandom_range(0, 19);
      if (sel < 7) begin
        // point a register into the data memory, then load, store and preload around it
        ptr = 5'($urandom_range(1, 31));
        exec_instr(enc_i(OP_LUI, 5'($urandom), ptr, 16'h1000));
        exec_instr(enc_i(OP_ORI, ptr, ptr, {14'($urandom), 2'b00}));
        k = $urandom_range(2, 8);
        repeat (k) begin
          sel = $urandom_range(0, 11);
          if (sel == 0) off = 16'($urandom);
          else if (sel == 1) off = 16'($urandom_range(0, 255) * 4 + $urandom_range(1, 3) - 512);
          else off = 16'($urandom_range(0, 255) * 4 - 512);
          if (sel == 11) begin
            near = 14'((gpr[ptr] - DATA_BASE) >> 2);
            near = near + 14'($urandom_range(0, 31)) - 14'd16;
            send_request(REQ_PRELOAD, $urandom, near, $urandom, 5'($urandom));
          end else if ($urandom_range(0, 1) == 0) begin
            exec_instr(enc_i(OP_LW, ptr, pick_reg(), off));
          end else begin
            exec_instr(enc_i(OP_SW, ptr, pick_reg(), off));
          end
        end
      end else if (sel < 15) begin
        repeat ($urandom_range(3, 10)) exec_instr(rand_alu_instr());
      end else if (sel < 17) begin
        send_request(REQ_PRELOAD, $urandom, 14'($urandom), $urandom, 5'($urandom));
        send_request(REQ_READ, $urandom, 14'($urandom), $urandom, 5'($urandom));
      end else if (sel == 17) begin
        exec_instr($urandom);
      end else if (sel == 18) begin
        exec_instr(enc_r(6'($urandom), pick_reg(), pick_reg(), pick_reg(), 5'($urandom)));
      end else begin
        send_request(2'($urandom), $urandom, 14'($urandom), $urandom, 5'($urandom));
      end
    end
  endtask

  // Short bursts, each followed by a hold-off until every result is back.
  task automatic test_drain_pause();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b1;
    repeat (4) begin
      repeat (6) exec_instr(rand_alu_instr());
      in_valid <= 1'b0;
      do @(posedge clk); while (step_results.size() != 0);
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    opcode <= REQ_EXEC;
    instruction <= '0;
    word_index <= '0;
    word_value <= '0;
    register_index <= '0;
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    for (int i = 0; i < DMEM_WORDS; i++) dmem[i] = '1;
    pc_q = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_programs(500, 1'b1);
    test_drain_pause();
    test_random_programs(250, 1'b1);
    // full rate on both sides to finish
    test_random_programs(300, 1'b0);

    in_valid <= 1'b0;
    do @(posedge clk); while (step_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // End the run if nothing moves for too long.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("%0t: timeout, no request or result taken for %0d cycles", $time, idle_cycles);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### files.f
hdl/mse_pkg.sv
hdl/mse_ram.sv
hdl/mse_exec.sv
hdl/mips_subset_execute_step.sv
sim/tb_mips_subset_execute_step.sv
